FILE: rtl/top_k_flow_selector_assert.svh
// ----------------------------------------------------------------------------
// top_k_flow_selector assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TOP_K_FLOW_SELECTOR_ASSERT_SVH
`define TOP_K_FLOW_SELECTOR_ASSERT_SVH

`ifndef SYNTH
`define TKFS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("top_k_flow_selector: assertion failed");
`define TKFS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("top_k_flow_selector: assertion failed");
`define TKFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("top_k_flow_selector: assertion failed");
`else
`define TKFS_ASSERT_ALWAYS(label, clk, rst, expr)
`define TKFS_ASSERT_SAME(label, clk, rst, ante, cons)
`define TKFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/tkfs_pkg.sv
// ----------------------------------------------------------------------------
// tkfs_pkg
// shared widths, codes and types of the top-k flow selector
// ----------------------------------------------------------------------------
package tkfs_pkg;

   localparam int TAG_W   = 64;
   localparam int COUNT_W = 32;
   localparam int CFG_W   = 7;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd10;

   localparam logic ACT_OFFER  = 1'b0;
   localparam logic ACT_EXPORT = 1'b1;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DROP_INSERT,
      OP_SHIFT_OUT
   } chain_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXPORT
   } sel_state_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] count;
      logic               le;
   } cell_link_type;

endpackage

FILE: rtl/tkfs_if.sv
// ----------------------------------------------------------------------------
// tkfs channel interfaces
// valid/ready channels for offered items and exported records
// ----------------------------------------------------------------------------
interface tkfs_req_if import tkfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [TAG_W-1:0]   flow_tag;
   logic [COUNT_W-1:0] packet_count;

   modport source (output valid, output action, output flow_tag, output packet_count,
                   input ready);
   modport sink (input valid, input action, input flow_tag, input packet_count,
                 output ready);
endinterface

interface tkfs_rsp_if import tkfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TAG_W-1:0]   out_flow_tag;
   logic [COUNT_W-1:0] out_packet_count;
   logic               last_of_export;

   modport source (output valid, output out_flow_tag, output out_packet_count,
                   output last_of_export, input ready);
   modport sink (input valid, input out_flow_tag, input out_packet_count,
                 input last_of_export, output ready);
endinterface

FILE: rtl/tkfs_cell.sv
// ----------------------------------------------------------------------------
// tkfs_cell
// one slot of the sorted record chain, trades records with its neighbors
// ----------------------------------------------------------------------------
module tkfs_cell import tkfs_pkg::*; (
   input  logic               clock,
   input  chain_op_type       op,
   input  logic               in_use,
   input  logic [TAG_W-1:0]   new_tag,
   input  logic [COUNT_W-1:0] new_count,
   input  cell_link_type      left_link,
   input  cell_link_type      right_link,
   output cell_link_type      own_link
);

   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               le;

   // stored record sorts at or before the offered one
   assign le = in_use && (count_ff <= new_count);

   always_comb begin
      tag_in   = tag_ff;
      count_in = count_ff;
      case (op)
         OP_INSERT: begin
            if (!le && left_link.le) begin
               tag_in   = new_tag;
               count_in = new_count;
            end else if (!le) begin
               tag_in   = left_link.tag;
               count_in = left_link.count;
            end
         end
         OP_DROP_INSERT: begin
            if (right_link.le) begin
               tag_in   = right_link.tag;
               count_in = right_link.count;
            end else if (le) begin
               tag_in   = new_tag;
               count_in = new_count;
            end
         end
         OP_SHIFT_OUT: begin
            tag_in   = right_link.tag;
            count_in = right_link.count;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      count_ff <= count_in;
   end

   assign own_link = '{tag: tag_ff, count: count_ff, le: le};

endmodule

FILE: rtl/top_k_flow_selector.sv
// ----------------------------------------------------------------------------
// top_k_flow_selector
// keeps the heaviest flows in a sorted chain of cells and exports them on tick
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_chan  in   valid / ready      action, flow_tag, packet_count
//  rsp_chan  out  valid / ready      out_flow_tag, out_packet_count, last_of_export
//  csr_      in   write enable only  flows_in_use
//
//  offers are accepted back to back
//  an export tick drains the store, the chain shifting one record a cycle into
//  the output register; req ready is low while records drain, and a stalled
//  rsp side holds the chain
//  synchronous reset empties the store at once, no clearing pass
// ----------------------------------------------------------------------------
`include "top_k_flow_selector_assert.svh"

module top_k_flow_selector import tkfs_pkg::*; #(
   parameter int MAX_FLOWS = 64
) (
   input  logic             clock,
   input  logic             reset,
   tkfs_req_if.sink         req_chan,
   tkfs_rsp_if.source       rsp_chan,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data
);

   localparam int OCC_W = $clog2(MAX_FLOWS + 1);

   sel_state_type      state_ff, state_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [CFG_W-1:0]   flows_ff;
   logic [CFG_W-1:0]   cap;
   logic               full;
   logic               gt_head;
   logic               req_fire;
   logic               load_out;
   chain_op_type       op;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]   rsp_tag_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_last_ff;

   cell_link_type      links [MAX_FLOWS];

   always_ff @(posedge clock) begin
      if (reset) begin
         flows_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         flows_ff <= csr_write_data;
      end
   end

   // capacity clamped to one..MAX_FLOWS
   always_comb begin
      cap = flows_ff;
      if (flows_ff == '0) begin
         cap = CFG_W'(1);
      end else if (flows_ff > CFG_W'(MAX_FLOWS)) begin
         cap = CFG_W'(MAX_FLOWS);
      end
   end

   assign full     = CFG_W'(occ_ff) >= cap;
   assign gt_head  = req_chan.packet_count > links[0].count;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      op             = OP_HOLD;
      load_out       = 1'b0;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.action == ACT_EXPORT) begin
                  if (occ_ff != '0) begin
                     state_in = ST_EXPORT;
                  end
               end else if (!full) begin
                  op     = OP_INSERT;
                  occ_in = occ_ff + OCC_W'(1);
               end else if (occ_ff != '0 && gt_head) begin
                  op = OP_DROP_INSERT;
               end
            end
         end
         ST_EXPORT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               op       = OP_SHIFT_OUT;
               load_out = 1'b1;
               occ_in   = occ_ff - OCC_W'(1);
               if (occ_ff == OCC_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_FLOWS; gi++) begin : g_cell
         cell_link_type left_link;
         cell_link_type right_link;
         logic          in_use;

         assign in_use = occ_ff > OCC_W'(gi);

         if (gi == 0) begin : g_head
            assign left_link = '{tag: req_chan.flow_tag, count: req_chan.packet_count,
                                 le: 1'b1};
         end else begin : g_body
            assign left_link = links[gi-1];
         end

         if (gi == MAX_FLOWS - 1) begin : g_tail
            assign right_link = '{tag: links[gi].tag, count: links[gi].count, le: 1'b0};
         end else begin : g_inner
            assign right_link = links[gi+1];
         end

         tkfs_cell u_cell (
            .clock      (clock),
            .op         (op),
            .in_use     (in_use),
            .new_tag    (req_chan.flow_tag),
            .new_count  (req_chan.packet_count),
            .left_link  (left_link),
            .right_link (right_link),
            .own_link   (links[gi])
         );
      end
   endgenerate

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tag_ff   <= links[0].tag;
         rsp_count_ff <= links[0].count;
         rsp_last_ff  <= occ_ff == OCC_W'(1);
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.out_flow_tag     = rsp_tag_ff;
   assign rsp_chan.out_packet_count = rsp_count_ff;
   assign rsp_chan.last_of_export   = rsp_last_ff;

   `TKFS_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= OCC_W'(MAX_FLOWS))
   `TKFS_ASSERT_SAME(a_export_nonempty, clock, reset, state_ff == ST_EXPORT, occ_ff != '0)
   `TKFS_ASSERT_NEXT(a_offer_grows, clock, reset,
      req_fire && req_chan.action == ACT_OFFER && !full, occ_ff == $past(occ_ff) + OCC_W'(1))
   `TKFS_ASSERT_NEXT(a_last_ends, clock, reset,
      load_out && occ_ff == OCC_W'(1), state_ff == ST_IDLE && occ_ff == '0 && rsp_last_ff)

endmodule

FILE: tb/top_k_export_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_export_checker
// watches the request, result and csr ports of the top-k flow selector, keeps
// its own sorted store of the heaviest flows, and compares every exported
// record with the one the store says should come next
// ----------------------------------------------------------------------------
module top_k_export_checker import tkfs_pkg::*; #(
   parameter int MAX_FLOWS = 64
) (
   input  logic             clock,
   input  logic             reset,
   tkfs_req_if              req_mon,
   tkfs_rsp_if              rsp_mon,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data,
   output int               error_count,
   output int               pending_results
);

   logic [TAG_W-1:0]   kept_tags [MAX_FLOWS];
   logic [COUNT_W-1:0] kept_counts [MAX_FLOWS];
   int                 kept_fill;
   logic [CFG_W-1:0]   flow_limit;
   cell_link_type      expected_exports [$];

   initial begin
      error_count     = 0;
      pending_results = 0;
      kept_fill       = 0;
      flow_limit      = CFG_RESET;
   end

   function automatic int limit_in_force();
      int c;
      c = int'(flow_limit);
      if (c < 1) c = 1;
      if (c > MAX_FLOWS) c = MAX_FLOWS;
      return c;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // equal counts go behind the ones already kept
   task automatic place_sorted(input logic [TAG_W-1:0] tag, input logic [COUNT_W-1:0] cnt);
      int pos;
      pos = 0;
      if (kept_fill >= MAX_FLOWS) return;
      while (pos < kept_fill && kept_counts[pos] <= cnt) pos++;
      for (int i = kept_fill; i > pos; i--) begin
         kept_tags[i]   = kept_tags[i-1];
         kept_counts[i] = kept_counts[i-1];
      end
      kept_tags[pos]   = tag;
      kept_counts[pos] = cnt;
      kept_fill++;
   endtask

   task automatic predict_offer(input logic [TAG_W-1:0] tag, input logic [COUNT_W-1:0] cnt);
      if (kept_fill < limit_in_force()) begin
         place_sorted(tag, cnt);
      end else if (kept_fill > 0 && cnt > kept_counts[0]) begin
         for (int i = 1; i < kept_fill; i++) begin
            kept_tags[i-1]   = kept_tags[i];
            kept_counts[i-1] = kept_counts[i];
         end
         kept_fill--;
         place_sorted(tag, cnt);
      end
   endtask

   task automatic predict_export();
      cell_link_type rec;
      for (int k = 0; k < kept_fill; k++) begin
         rec.tag   = kept_tags[k];
         rec.count = kept_counts[k];
         rec.le    = (k == kept_fill - 1);
         expected_exports.push_back(rec);
      end
      kept_fill = 0;
   endtask

   task automatic check_record();
      cell_link_type want;
      if (expected_exports.size() == 0) begin
         report_mismatch($sformatf("unexpected record tag %h count %h",
                                   rsp_mon.out_flow_tag, rsp_mon.out_packet_count));
         return;
      end
      want = expected_exports.pop_front();
      if (rsp_mon.out_flow_tag !== want.tag)
         report_mismatch($sformatf("flow tag %h, want %h", rsp_mon.out_flow_tag, want.tag));
      if (rsp_mon.out_packet_count !== want.count)
         report_mismatch($sformatf("packet count %h, want %h",
                                   rsp_mon.out_packet_count, want.count));
      if (rsp_mon.last_of_export !== want.le)
         report_mismatch($sformatf("last flag %b, want %b", rsp_mon.last_of_export, want.le));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kept_fill  = 0;
         flow_limit = CFG_RESET;
         expected_exports.delete();
      end else begin
         if (csr_write_enable) flow_limit = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) check_record();
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_OFFER)
               predict_offer(req_mon.flow_tag, req_mon.packet_count);
            else
               predict_export();
         end
      end
      pending_results = expected_exports.size();
   end

endmodule

FILE: tb/tb_top_k_flow_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_flow_selector
// drives flow records and export ticks into the top-k flow selector under
// several store sizes and pacing modes, with a long result-side hold-off;
// the checker beside the block predicts and compares every exported record
// ----------------------------------------------------------------------------
module tb_top_k_flow_selector;
   import tkfs_pkg::*;

   localparam int MAX_FLOWS   = 64;
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_PAD   = 70;
   localparam int CYCLE_LIMIT = 200000;

   typedef enum int {
      PACE_FULL,
      PACE_SEND_IDLE,
      PACE_RECV_STALL,
      PACE_BOTH
   } pace_type;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [CFG_W-1:0] csr_write_data;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               hold_requests  = 0;
   int               cycle_count    = 0;
   int               error_count;
   int               pending_results;

   tkfs_req_if req_chan ();
   tkfs_rsp_if rsp_chan ();

   top_k_flow_selector #(
      .MAX_FLOWS(MAX_FLOWS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   top_k_export_checker #(
      .MAX_FLOWS(MAX_FLOWS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      int holds_seen;
      hold_left      = 0;
      holds_seen     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic int effective_limit(input int v);
      if (v < 1) return 1;
      if (v > MAX_FLOWS) return MAX_FLOWS;
      return v;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return $urandom_range(1000);
         2: return $urandom;
         default: return $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   function automatic logic [TAG_W-1:0] pick_tag();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic set_pace(input pace_type mode);
      case (mode)
         PACE_FULL: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         PACE_SEND_IDLE: begin
            send_idle_pct  = 65;
            recv_stall_pct = 0;
         end
         PACE_RECV_STALL: begin
            send_idle_pct  = 0;
            recv_stall_pct = 65;
         end
         default: begin
            send_idle_pct  = 12;
            recv_stall_pct = 12;
         end
      endcase
   endtask

   task automatic present_record(input logic act, input logic [TAG_W-1:0] tag,
                                 input logic [COUNT_W-1:0] cnt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.action       <= act;
      req_chan.flow_tag     <= tag;
      req_chan.packet_count <= cnt;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic offer(input logic [TAG_W-1:0] tag, input logic [COUNT_W-1:0] cnt);
      present_record(ACT_OFFER, tag, cnt);
   endtask

   task automatic export_tick();
      present_record(ACT_EXPORT, pick_tag(), pick_count());
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_flow_limit(input logic [CFG_W-1:0] v);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int phase_caps [7];
      int phase_items [7];
      int cap;
      int sent;
      int run_len;

      reset                 <= 1'b1;
      csr_write_enable      <= 1'b0;
      csr_write_data        <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.action       <= ACT_OFFER;
      req_chan.flow_tag     <= '0;
      req_chan.packet_count <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty export, extremes, replacement, equal and smaller count when full
      set_pace(PACE_FULL);
      set_flow_limit(2);
      present_record(ACT_EXPORT, '1, '1);
      offer('0, '0);
      offer('1, '1);
      offer(64'h0000_0000_0000_00A5, 5);
      offer(64'h0000_0000_0000_00B6, 5);
      offer(64'h0000_0000_0000_00C7, 4);
      present_record(ACT_EXPORT, '0, '0);

      // ties kept in arrival order, then limit lowered below the fill
      set_flow_limit(4);
      offer(64'h11, 7);
      offer(64'h12, 7);
      offer(64'h13, 3);
      offer(64'h14, 7);
      set_flow_limit(1);
      offer(64'h15, 8);
      offer(64'h16, 7);
      export_tick();

      // limit of zero acts as one
      set_flow_limit(0);
      offer(64'h21, 9);
      offer(64'h22, 2);
      offer(64'h23, 10);
      export_tick();

      phase_caps  = '{3, 64, 127, 1, 0, 10, 0};
      phase_items = '{20, 52, 15, 12, 10, 13, 20};
      phase_caps[6] = $urandom_range(1, 127);

      for (int p = 0; p < 7; p++) begin
         set_flow_limit(CFG_W'(phase_caps[p]));
         set_pace(pace_type'(p % 4));
         if (p == 0) hold_requests++;
         cap  = effective_limit(phase_caps[p]);
         sent = 0;
         while (sent < phase_items[p]) begin
            if ($urandom_range(9) == 0) begin
               export_tick();
               sent++;
            end else begin
               run_len = $urandom_range(1, 2 * cap + 2);
               for (int i = 0; i < run_len && sent < phase_items[p]; i++) begin
                  offer(pick_tag(), pick_count());
                  sent++;
               end
               export_tick();
               sent++;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_PAD) @(posedge clock);
      if (error_count == 0 && pending_results == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
